// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks of the display converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset.
`define RH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RH_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hdl/rhts_pkg.sv
// ----------------------------------------------------------------------------
// rhts_pkg
// Widths, fixed-point constants, segment codes and shared types of the
// temperature / humidity to seven-segment converter.
// ----------------------------------------------------------------------------
package rhts_pkg;

  localparam int RAW_W   = 16;
  localparam int VAL_W   = 15;
  localparam int SEG_W   = 8;
  localparam int PLACE_W = 2;
  localparam int DIG_W   = 4;

  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 56;

  // Scale products: raw * gain
  localparam int GAIN_W = 17;
  localparam int PROD_W = RAW_W + GAIN_W;
  localparam logic [GAIN_W-1:0] T_GAIN = 17'd17572;
  // 1250000 / 16, the humidity divisor is scaled by the same 16
  localparam logic [GAIN_W-1:0] H_GAIN = 17'd78125;

  // Signed numerator width before the truncating divide
  localparam int NUM_W = 35;
  localparam logic signed [NUM_W-1:0] T_OFFSET = 35'sd307036160;
  localparam logic signed [NUM_W-1:0] H_OFFSET = 35'sd399360000;
  localparam int T_SHIFT = 16;
  localparam int H_SHIFT = 14;
  // Compensation gain 61440 = 2^16 - 2^12
  localparam int COMP_HI_SH = 16;
  localparam int COMP_LO_SH = 12;

  // Magnitude after the power-of-two part of the humidity divide
  localparam int MAG_W = 19;

  // Divide by 25 as multiply by reciprocal
  localparam int DIV25_MW = 20;
  localparam logic [DIV25_MW-1:0] DIV25_MUL = 20'd671089;
  localparam int DIV25_SH = 24;

  // Decimal split reciprocals, exact for magnitudes up to 2^14
  localparam int RCP_W = 16;
  localparam logic [RCP_W-1:0] RCP10    = 16'd52429;
  localparam int               RCP10_SH = 19;
  localparam logic [RCP_W-1:0] RCP100   = 16'd41944;
  localparam int               RCP100_SH = 22;
  localparam logic [RCP_W-1:0] RCP1K    = 16'd16778;
  localparam int               RCP1K_SH = 24;
  localparam logic [RCP_W-1:0] RCP10K   = 16'd13422;
  localparam int               RCP10K_SH = 27;

  localparam logic [PLACE_W-1:0] PLACE_ONE = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_TWO = 2'd2;

  localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
  localparam logic [SEG_W-1:0] SEG_ERR   = 8'h79;
  localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;

  // Temperature window for two decimals, and humidity threshold
  localparam logic signed [VAL_W-1:0] T_TWO_LO = -15'sd1000;
  localparam logic signed [VAL_W-1:0] T_TWO_HI = 15'sd10000;
  localparam logic signed [VAL_W-1:0] H_TWO_LO = 15'sd1000;

  // Load strobes of the pipeline registers
  typedef struct packed {
    logic ld_in;
    logic ld_prod;
    logic ld_mag;
    logic ld_val;
    logic ld_out;
  } pipe_en_t;

  function automatic logic [SEG_W-1:0] seg_of(input logic [DIG_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = SEG_ERR;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/rhts_ctrl.sv
// ----------------------------------------------------------------------------
// rhts_ctrl
// Valid tracking and load strobes of the five-register pipeline.
// ----------------------------------------------------------------------------
module rhts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              m_ready_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  output rhts_pkg::pipe_en_t en_o
);
  import rhts_pkg::*;

  logic v_in_q, v_prod_q, v_mag_q, v_val_q, v_out_q;
  logic rdy_in, rdy_prod, rdy_mag, rdy_val, rdy_out;

  // A stage takes a new item when empty or when its item moves on
  assign rdy_out  = !v_out_q  || m_ready_i;
  assign rdy_val  = !v_val_q  || rdy_out;
  assign rdy_mag  = !v_mag_q  || rdy_val;
  assign rdy_prod = !v_prod_q || rdy_mag;
  assign rdy_in   = !v_in_q   || rdy_prod;

  assign en_o.ld_in   = s_valid_i && rdy_in;
  assign en_o.ld_prod = v_in_q    && rdy_prod;
  assign en_o.ld_mag  = v_prod_q  && rdy_mag;
  assign en_o.ld_val  = v_mag_q   && rdy_val;
  assign en_o.ld_out  = v_val_q   && rdy_out;

  assign s_ready_o = rdy_in;
  assign m_valid_o = v_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q   <= 1'b0;
      v_prod_q <= 1'b0;
      v_mag_q  <= 1'b0;
      v_val_q  <= 1'b0;
      v_out_q  <= 1'b0;
    end else begin
      if (rdy_in)   v_in_q   <= s_valid_i;
      if (rdy_prod) v_prod_q <= v_in_q;
      if (rdy_mag)  v_mag_q  <= v_prod_q;
      if (rdy_val)  v_val_q  <= v_mag_q;
      if (rdy_out)  v_out_q  <= v_val_q;
    end
  end

endmodule

// File: hdl/rhts_convert.sv
// ----------------------------------------------------------------------------
// rhts_convert
// Raw code to signed hundredths: scale multiply, offset and compensation,
// truncating divide. Holds the last temperature.
// ----------------------------------------------------------------------------
module rhts_convert (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rhts_pkg::pipe_en_t                en_i,
  input  logic [rhts_pkg::RAW_W-1:0]        raw_code_i,
  input  logic                              is_humidity_i,
  output logic signed [rhts_pkg::VAL_W-1:0] val_o,
  output logic                              hum_o
);
  import rhts_pkg::*;

  // Input register
  logic [RAW_W-1:0] raw_q;
  logic             hum1_q;
  // Product register
  logic [PROD_W-1:0] prod_q;
  logic              hum2_q;
  // Magnitude register
  logic [MAG_W-1:0] mag_q;
  logic             neg3_q, hum3_q;
  // Value register
  logic signed [VAL_W-1:0] val_q;
  logic                    hum4_q;
  // Temperature used for humidity compensation
  logic signed [VAL_W-1:0] last_temp_q;

  logic [GAIN_W-1:0]        gain;
  logic [PROD_W-1:0]        prod_d;
  logic signed [NUM_W-1:0]  prod_ext, tc_ext, num_w;
  logic [NUM_W-1:0]         abs_w;
  logic                     num_neg;
  logic [MAG_W-1:0]         mag_d;
  logic [VAL_W-1:0]         t_mag;
  logic signed [VAL_W-1:0]  t_val;
  logic [MAG_W+DIV25_MW-1:0] q25_prod;
  logic [VAL_W-1:0]         mag_v;
  logic signed [VAL_W-1:0]  val_d;

  // Scale
  assign gain   = hum1_q ? H_GAIN : T_GAIN;
  assign prod_d = PROD_W'(raw_q) * PROD_W'(gain);

  // Offset, compensation, sign and power-of-two divide
  assign prod_ext = signed'({{(NUM_W-PROD_W){1'b0}}, prod_q});
  assign tc_ext   = {{(NUM_W-VAL_W){last_temp_q[VAL_W-1]}}, last_temp_q};

  always_comb begin
    if (hum2_q) begin
      num_w = prod_ext + (tc_ext <<< COMP_HI_SH) - (tc_ext <<< COMP_LO_SH) - H_OFFSET;
    end else begin
      num_w = prod_ext - T_OFFSET;
    end
  end

  assign num_neg = num_w[NUM_W-1];
  assign abs_w   = num_neg ? NUM_W'(-num_w) : NUM_W'(num_w);
  assign mag_d   = hum2_q ? MAG_W'(abs_w >> H_SHIFT) : MAG_W'(abs_w >> T_SHIFT);
  assign t_mag   = VAL_W'(abs_w >> T_SHIFT);
  assign t_val   = num_neg ? -signed'(t_mag) : signed'(t_mag);

  // Humidity: finish the divide by 25
  assign q25_prod = (MAG_W+DIV25_MW)'(mag_q) * (MAG_W+DIV25_MW)'(DIV25_MUL);
  assign mag_v    = hum3_q ? VAL_W'(q25_prod >> DIV25_SH) : VAL_W'(mag_q);
  assign val_d    = neg3_q ? -signed'(mag_v) : signed'(mag_v);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_temp_q <= '0;
    end else if (en_i.ld_mag && !hum2_q) begin
      last_temp_q <= t_val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_in) begin
      raw_q  <= raw_code_i;
      hum1_q <= is_humidity_i;
    end
    if (en_i.ld_prod) begin
      prod_q <= prod_d;
      hum2_q <= hum1_q;
    end
    if (en_i.ld_mag) begin
      mag_q  <= mag_d;
      neg3_q <= num_neg;
      hum3_q <= hum2_q;
    end
    if (en_i.ld_val) begin
      val_q  <= val_d;
      hum4_q <= hum3_q;
    end
  end

  assign val_o = val_q;
  assign hum_o = hum4_q;

endmodule

// File: hdl/rhts_display.sv
// ----------------------------------------------------------------------------
// rhts_display
// Decimal split, point placement and segment encoding into the result
// register.
// ----------------------------------------------------------------------------
module rhts_display (
  input  logic                              clk_i,
  input  rhts_pkg::pipe_en_t                en_i,
  input  logic signed [rhts_pkg::VAL_W-1:0] val_i,
  input  logic                              hum_i,
  output logic [rhts_pkg::SEG_W-1:0]        seg_units_o,
  output logic [rhts_pkg::SEG_W-1:0]        seg_tens_o,
  output logic [rhts_pkg::SEG_W-1:0]        seg_hundreds_o,
  output logic [rhts_pkg::SEG_W-1:0]        seg_thousands_o,
  output logic [rhts_pkg::PLACE_W-1:0]      point_place_o,
  output logic signed [rhts_pkg::VAL_W-1:0] value_centi_o
);
  import rhts_pkg::*;

  localparam int PW = VAL_W + RCP_W;

  logic                 neg;
  logic [VAL_W-1:0]     absv;
  logic [PW-1:0]        p1, p2, p3, p4;
  logic [VAL_W-1:0]     q1, q2, q3, q4;
  logic [DIG_W-1:0]     d0, d1, d2, d3, d4;
  logic [PLACE_W-1:0]   place;
  logic [DIG_W-1:0]     dig [4];
  logic [SEG_W-1:0]     code [4];

  logic [SEG_W-1:0]        seg_q [4];
  logic [PLACE_W-1:0]      place_q;
  logic signed [VAL_W-1:0] value_q;

  function automatic logic [DIG_W-1:0] low_digit(input logic [VAL_W-1:0] qa,
                                                 input logic [VAL_W-1:0] qb);
    logic [VAL_W-1:0] r;
    r = qa - ((qb << 3) + (qb << 1));
    return r[DIG_W-1:0];
  endfunction

  assign neg  = val_i[VAL_W-1];
  assign absv = neg ? VAL_W'(-val_i) : VAL_W'(val_i);

  // Quotients by 10, 100, 1000, 10000 in parallel
  assign p1 = PW'(absv) * PW'(RCP10);
  assign p2 = PW'(absv) * PW'(RCP100);
  assign p3 = PW'(absv) * PW'(RCP1K);
  assign p4 = PW'(absv) * PW'(RCP10K);
  assign q1 = VAL_W'(p1 >> RCP10_SH);
  assign q2 = VAL_W'(p2 >> RCP100_SH);
  assign q3 = VAL_W'(p3 >> RCP1K_SH);
  assign q4 = VAL_W'(p4 >> RCP10K_SH);

  assign d0 = low_digit(absv, q1);
  assign d1 = low_digit(q1, q2);
  assign d2 = low_digit(q2, q3);
  assign d3 = low_digit(q3, q4);
  assign d4 = low_digit(q4, '0);

  always_comb begin
    if (hum_i) begin
      place = (val_i > H_TWO_LO) ? PLACE_TWO : PLACE_ONE;
    end else begin
      place = (val_i > T_TWO_LO && val_i < T_TWO_HI) ? PLACE_TWO : PLACE_ONE;
    end
  end

  // One decimal drops the hundredths digit
  always_comb begin
    if (place == PLACE_TWO) begin
      dig[0] = d0; dig[1] = d1; dig[2] = d2; dig[3] = d3;
    end else begin
      dig[0] = d1; dig[1] = d2; dig[2] = d3; dig[3] = d4;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      // Negative humidity: nonzero remainders show E
      code[k] = (hum_i && neg && dig[k] != '0) ? SEG_ERR : seg_of(dig[k]);
      if (PLACE_W'(k) == place) code[k] = code[k] | SEG_DP;
    end
    if (!hum_i && neg) code[3] = SEG_MINUS;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.ld_out) begin
      for (int k = 0; k < 4; k++) seg_q[k] <= code[k];
      place_q <= place;
      value_q <= val_i;
    end
  end

  assign seg_units_o     = seg_q[0];
  assign seg_tens_o      = seg_q[1];
  assign seg_hundreds_o  = seg_q[2];
  assign seg_thousands_o = seg_q[3];
  assign point_place_o   = place_q;
  assign value_centi_o   = value_q;

endmodule

// File: hdl/rh_temp_code_to_seven_segment_top.sv
// ----------------------------------------------------------------------------
// rh_temp_code_to_seven_segment_top
// Sensor code to four seven-segment digits with temperature compensation.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one raw 16-bit sensor code per transfer in tdata,
//   with tuser set for a humidity reading and clear for a temperature.
//   Master stream returns one result per input transfer: four segment
//   codes (lowest digit first, bit 7 the decimal point), the point place
//   and the value in signed hundredths.
//   Throughput: one transfer per cycle while the receiver does not stall,
//   set by the five-register pipeline (input, product, magnitude, value,
//   result registers); each reading passes them in order and is presented
//   from the result register. Each stage is at most one multiply deep.
//   A temperature updates the stored compensation value as it leaves the
//   product stage, so any later humidity sees it without forwarding.
//   Reset empties the pipeline and clears the stored temperature to zero
//   degrees; humidity before any temperature is compensated at zero.
//   When the receiver stalls, the result holds and earlier stages keep
//   filling until the pipeline is full; then tready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rh_temp_code_to_seven_segment_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] raw_code
  input  logic [rhts_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // [0] is_humidity
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] seg_units, [15:8] seg_tens, [23:16] seg_hundreds,
  // [31:24] seg_thousands, [33:32] point_place, [48:34] value_centi,
  // [55:49] zero
  output logic [rhts_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import rhts_pkg::*;

  pipe_en_t                en;
  logic signed [VAL_W-1:0] val;
  logic                    hum;
  logic [SEG_W-1:0]        seg_units, seg_tens, seg_hundreds, seg_thousands;
  logic [PLACE_W-1:0]      point_place;
  logic signed [VAL_W-1:0] value_centi;

  // Handshake and stage advance
  rhts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .en_o      (en)
  );

  // Fixed-point conversion to hundredths
  rhts_convert u_convert (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .raw_code_i    (s_axis_tdata[RAW_W-1:0]),
    .is_humidity_i (s_axis_tuser[0]),
    .val_o         (val),
    .hum_o         (hum)
  );

  // Digits and segment codes into the result register
  rhts_display u_display (
    .clk_i           (clk_i),
    .en_i            (en),
    .val_i           (val),
    .hum_i           (hum),
    .seg_units_o     (seg_units),
    .seg_tens_o      (seg_tens),
    .seg_hundreds_o  (seg_hundreds),
    .seg_thousands_o (seg_thousands),
    .point_place_o   (point_place),
    .value_centi_o   (value_centi)
  );

  // Pack fields lowest first, pad to whole bytes
  assign m_axis_tdata = {
    {(M_TDATA_W - 4*SEG_W - PLACE_W - VAL_W){1'b0}},
    value_centi, point_place, seg_thousands, seg_hundreds, seg_tens, seg_units
  };

  // Only one or two decimals are ever shown
  `RH_ASSERT_IMPL(a_place_legal, m_axis_tvalid,
    point_place == PLACE_ONE || point_place == PLACE_TWO, "point place out of range")

  // Exactly one digit carries the decimal point
  `RH_ASSERT_IMPL(a_dp_onehot, m_axis_tvalid,
    $onehot({seg_thousands[SEG_W-1], seg_hundreds[SEG_W-1], seg_tens[SEG_W-1],
             seg_units[SEG_W-1]}), "decimal point not on exactly one digit")

  // An empty result register never holds back the input
  `RH_ASSERT(a_ready_when_empty, !m_axis_tvalid |-> s_axis_tready,
    "input stalled while output empty")

endmodule

// File: tb/tb_rh_temp_code_to_seven_segment_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rh_temp_code_to_seven_segment_top
// Self-checking bench for the sensor code to seven-segment converter.
// Each accepted reading is converted by a fixed-point model of the
// temperature and compensated humidity formulas. The expected digits are
// queued in order and compared field by field with every result transfer.
// Stimulus is a directed set of edge codes, then random readings, under
// three patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module tb_rh_temp_code_to_seven_segment_top;
  import rhts_pkg::*;

  localparam int CLK_HALF_NS   = 6;
  localparam int RESET_CYCLES  = 12;
  localparam int DRAIN_CYCLES  = 16;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PER_PHASE = 430;

  // Fixed-point scale factors, values in hundredths
  localparam longint T_GAIN_CENTI = 17572;
  localparam longint T_BIAS_CENTI = 64'd4685 * 65536;
  localparam longint T_DIV        = 65536;
  localparam longint H_GAIN_CENTI = 1250000;
  localparam longint H_DIV        = 6553600;
  localparam longint H_BIAS_CENTI = 64'd600 * 6553600;
  localparam longint H_COMP_GAIN  = 64'd15 * 65536;
  localparam longint H_COMP_REF   = 2500;

  // Two-decimal windows in hundredths
  localparam longint T_TWO_LOW  = -1000;
  localparam longint T_TWO_HIGH = 10000;
  localparam longint H_TWO_LOW  = 1000;

  // Temperature codes at the edges of the two-decimal window, and near zero
  localparam int RAW_T_NEAR_M10  = 13744;
  localparam int RAW_T_NEAR_P100 = 54769;
  localparam int RAW_T_NEAR_ZERO = 17473;

  localparam logic [SEG_W-1:0] DIGIT_GLYPH [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the display word of each reading, keeps the stored
  // temperature for humidity compensation, and checks results in order.
  // --------------------------------------------------------------------------
  class display_scoreboard;
    // Same layout as the low bits of the result tdata
    typedef struct packed {
      logic [VAL_W-1:0]            value;
      logic [PLACE_W-1:0]          place;
      logic [3:0][SEG_W-1:0]       seg;
    } readout_t;

    readout_t             pending[$];
    logic signed [VAL_W-1:0] last_temp_c;
    int unsigned          n_mismatch;

    function new();
      last_temp_c = '0;
      n_mismatch  = 0;
    endfunction

    function void note_reading(logic [RAW_W-1:0] code, logic hum);
      longint   raw, val, num, mag, tc, d;
      logic [PLACE_W-1:0] place;
      bit       neg_temp;
      readout_t r;
      raw      = code;
      neg_temp = 1'b0;
      if (!hum) begin
        val = (raw * T_GAIN_CENTI - T_BIAS_CENTI) / T_DIV;
        last_temp_c = val[VAL_W-1:0];
        if (val > T_TWO_LOW && val < T_TWO_HIGH) begin
          num = val;
          place = PLACE_TWO;
        end else begin
          num = val / 10;
          place = PLACE_ONE;
        end
        // Show the magnitude; the minus sign replaces the top digit
        if (val < 0) begin
          neg_temp = 1'b1;
          num = -num;
        end
      end else begin
        tc  = last_temp_c;
        val = (raw * H_GAIN_CENTI - H_BIAS_CENTI + H_COMP_GAIN * (tc - H_COMP_REF)) / H_DIV;
        if (val > H_TWO_LOW) begin
          num = val;
          place = PLACE_TWO;
        end else begin
          num = val / 10;
          place = PLACE_ONE;
        end
      end
      mag = (num < 0) ? -num : num;
      for (int k = 0; k < 4; k++) begin
        d   = mag % 10;
        mag = mag / 10;
        // Negative humidity: any nonzero remainder shows E
        if (num < 0 && d != 0) r.seg[k] = SEG_ERR;
        else r.seg[k] = DIGIT_GLYPH[d];
        if (k == place) r.seg[k] = r.seg[k] | SEG_DP;
      end
      if (neg_temp) r.seg[3] = SEG_MINUS;
      r.place = place;
      r.value = val[VAL_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] word);
      readout_t want, got;
      bit       bad;
      got = word[$bits(readout_t)-1:0];
      if (pending.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: result with nothing outstanding: %h", $realtime, word);
        return;
      end
      want = pending.pop_front();
      bad = 1'b0;
      for (int k = 0; k < 4; k++)
        if (got.seg[k] !== want.seg[k]) bad = 1'b1;
      if (got.place !== want.place) bad = 1'b1;
      if (got.value !== want.value) bad = 1'b1;
      if (bad) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: mismatch seg exp %h_%h_%h_%h got %h_%h_%h_%h place exp %0d got %0d value exp %0d got %0d",
                   $realtime, want.seg[3], want.seg[2], want.seg[1], want.seg[0],
                   got.seg[3], got.seg[2], got.seg[1], got.seg[0],
                   want.place, got.place, $signed(want.value), $signed(got.value));
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function bit failed();
      return (n_mismatch != 0) || (pending.size() != 0);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata = '0;   // [15:0] raw_code
  logic [0:0]              s_axis_tuser = '0;   // [0] is_humidity
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // [7:0] seg_units, [15:8] seg_tens, [23:16] seg_hundreds,
  // [31:24] seg_thousands, [33:32] point_place, [48:34] value_centi
  logic [M_TDATA_W-1:0]    m_axis_tdata;

  display_scoreboard sb = new();
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_idle_pct = 0;
  int unsigned       cycle_count   = 0;

  always #(CLK_HALF_NS) clk_i = ~clk_i;

  rh_temp_code_to_seven_segment_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Count cycles for the watchdog
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Receiver: stall at random; the value read here is the one from before
  // the edge, so it matches what the block saw
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold the reading until the transfer.
  // Valid stays high into the next reading when no idle cycle is drawn.
  // --------------------------------------------------------------------------
  task automatic send_reading(input logic [RAW_W-1:0] code, input logic hum);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= hum;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_reading(code, hum);
  endtask

  // Pause the sender until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  task automatic send_near(input int base, input logic hum);
    int code;
    code = base + int'($urandom_range(0, 80)) - 40;
    send_reading(RAW_W'(code), hum);
  endtask

  // Random readings: mostly a temperature followed by a humidity, so the
  // compensation path sees fresh values, plus readings near the decimal
  // placement edges and fully random noise
  task automatic run_random(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          send_reading(RAW_W'($urandom_range(0, 65535)), 1'b0);
          send_reading(RAW_W'($urandom_range(0, 65535)), 1'b1);
          sent += 2;
        end
        4: begin
          send_near(RAW_T_NEAR_M10, 1'b0);
          sent++;
        end
        5: begin
          send_near(($urandom_range(0, 1) != 0) ? RAW_T_NEAR_P100 : RAW_T_NEAR_ZERO, 1'b0);
          sent++;
        end
        6: begin
          // Humidity around its one/two decimal threshold
          send_reading(RAW_W'($urandom_range(9000, 12000)), 1'b1);
          sent++;
        end
        7: begin
          // Low humidity codes drive negative values
          send_reading(RAW_W'($urandom_range(0, 4000)), 1'b1);
          sent++;
        end
        default: begin
          send_reading(RAW_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
          sent++;
        end
      endcase
    end
  endtask

  // Watchdog: end the run if the results never drain
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: light stalls on both sides
    src_idle_pct  = 20;
    sink_idle_pct = 46;
    // Humidity before any temperature, compensated at zero degrees
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    // Lowest temperature: negative, one decimal, minus sign on top
    send_reading(16'h0000, 1'b0);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    // Highest temperature: then humidity runs past four digits
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    // Edges of the two-decimal temperature window
    send_reading(RAW_W'(RAW_T_NEAR_M10 - 1), 1'b0);
    send_reading(RAW_W'(RAW_T_NEAR_M10), 1'b0);
    send_reading(RAW_W'(RAW_T_NEAR_P100 - 1), 1'b0);
    send_reading(RAW_W'(RAW_T_NEAR_P100), 1'b0);
    // Around zero degrees, then humidity around its threshold
    send_reading(RAW_W'(RAW_T_NEAR_ZERO), 1'b0);
    send_reading(RAW_W'(RAW_T_NEAR_ZERO + 1), 1'b0);
    send_reading(16'd10354, 1'b1);
    send_reading(16'd10355, 1'b1);
    // Negative humidity with a zero remainder digit
    send_reading(16'd4587, 1'b1);
    send_reading(16'd4588, 1'b1);
    // Alternating bit patterns on both kinds
    send_reading(16'hAAAA, 1'b0);
    send_reading(16'h5555, 1'b1);
    send_reading(16'h5555, 1'b0);
    send_reading(16'hAAAA, 1'b1);
    drain_results();

    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Swap the stall pattern
    src_idle_pct  = 46;
    sink_idle_pct = 20;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Full rate on both sides
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);
    drain_results();

    // Let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.failed()) begin
      $display("[FAIL] regression broken");
    end else begin
      $display("[ OK ] regression clean");
    end
    $finish;
  end

endmodule
